// ===== design/frn_pkg.sv =====
// Shared types and constants for the fraction normalizer.
`timescale 1ns / 1ps
`default_nettype none

package frn_pkg;

   // Width of the numerator and denominator on the request side.
   localparam int DATA_WIDTH = 32;

   // Step and shift counters cover DATA_WIDTH - 1 at most.
   localparam int CNT_W = $clog2(DATA_WIDTH);

   // The shared subtractor works two bits wider than the data so its borrow is clean.
   localparam int EXT_W = DATA_WIDTH + 2;

   // Stream widths, rounded up to whole bytes.
   localparam int REQ_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8;

   typedef logic [DATA_WIDTH-1:0] data_type;

   // Handshake status from the arithmetic core to the stream wrapper.
   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

   // One reduced fraction.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] numerator;
      logic [DATA_WIDTH-2:0] denominator;
   } result_type;

endpackage : frn_pkg

`default_nettype wire

// ===== design/frn_core.sv =====
// Sequenced datapath: magnitudes, binary GCD and two restoring divisions on one subtractor.
`timescale 1ns / 1ps
`default_nettype none

module frn_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire frn_pkg::data_type   num_in,
   input  wire frn_pkg::data_type   den_in,
   input  wire logic                take,
   output frn_pkg::status_type      status,
   output frn_pkg::result_type      result
);

   import frn_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAGN,
      ST_MAGD,
      ST_STRIP,
      ST_ODD,
      ST_LOOP,
      ST_SCALE,
      ST_LOAD,
      ST_DIV,
      ST_SIGN,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic [DATA_WIDTH-1:0] a_ff;
   logic [DATA_WIDTH-1:0] b_ff;
   logic [DATA_WIDTH-1:0] an_ff;
   logic [DATA_WIDTH-1:0] ad_ff;
   logic [DATA_WIDTH-1:0] q_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] qn_ff;
   logic [DATA_WIDTH-1:0] qd_ff;
   logic [CNT_W-1:0]      k_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  sel_ff;
   logic                  neg_ff;

   logic [EXT_W-1:0]      sub_x;
   logic [EXT_W-1:0]      sub_y;
   logic [EXT_W-1:0]      diff;
   logic                  borrow;
   logic [DATA_WIDTH:0]   rem_shift;
   logic [DATA_WIDTH-1:0] q_next;

   // Operand selection for the one shared subtractor.
   assign rem_shift = {rem_ff, q_ff[DATA_WIDTH-1]};

   always_comb begin
      case (state_ff)
         ST_MAGN: begin
            sub_x = '0;
            sub_y = {2'b00, a_ff};
         end
         ST_MAGD: begin
            sub_x = '0;
            sub_y = {2'b00, b_ff};
         end
         ST_LOOP: begin
            sub_x = {2'b00, b_ff};
            sub_y = {2'b00, a_ff};
         end
         ST_DIV: begin
            sub_x = {1'b0, rem_shift};
            sub_y = {2'b00, a_ff};
         end
         ST_SIGN: begin
            sub_x = '0;
            sub_y = {2'b00, qn_ff};
         end
         default: begin
            sub_x = '0;
            sub_y = '0;
         end
      endcase
   end

   assign diff   = sub_x - sub_y;
   assign borrow = diff[EXT_W-1];
   assign q_next = {q_ff[DATA_WIDTH-2:0], ~borrow};

   // Sequencer. In the GCD phase a_ff ends up holding the divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  neg_ff <= num_in[DATA_WIDTH-1] ^ den_in[DATA_WIDTH-1];
                  a_ff   <= num_in;
                  b_ff   <= den_in;
                  k_ff   <= '0;
                  if (num_in == '0) begin
                     qn_ff    <= '0;
                     qd_ff    <= DATA_WIDTH'(1);
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_MAGN;
                  end
               end
            end
            ST_MAGN: begin
               if (a_ff[DATA_WIDTH-1]) begin
                  a_ff <= diff[DATA_WIDTH-1:0];
               end
               state_ff <= ST_MAGD;
            end
            ST_MAGD: begin
               an_ff <= a_ff;
               if (b_ff[DATA_WIDTH-1]) begin
                  b_ff  <= diff[DATA_WIDTH-1:0];
                  ad_ff <= diff[DATA_WIDTH-1:0];
               end else begin
                  ad_ff <= b_ff;
               end
               state_ff <= ST_STRIP;
            end
            // Remove common factors of two; a zero denominator makes the numerator the divisor.
            ST_STRIP: begin
               if (b_ff == '0) begin
                  state_ff <= ST_LOAD;
               end else if (!a_ff[0] && !b_ff[0]) begin
                  a_ff <= a_ff >> 1;
                  b_ff <= b_ff >> 1;
                  k_ff <= k_ff + 1'b1;
               end else begin
                  state_ff <= ST_ODD;
               end
            end
            ST_ODD: begin
               if (!a_ff[0]) begin
                  a_ff <= a_ff >> 1;
               end else begin
                  state_ff <= ST_LOOP;
               end
            end
            // One binary GCD step per cycle: halve, swap, or subtract.
            ST_LOOP: begin
               if (b_ff == '0) begin
                  state_ff <= ST_SCALE;
               end else if (!b_ff[0]) begin
                  b_ff <= b_ff >> 1;
               end else if (borrow) begin
                  a_ff <= b_ff;
                  b_ff <= a_ff;
               end else begin
                  b_ff <= diff[DATA_WIDTH-1:0];
               end
            end
            // Put the common factors of two back into the divisor.
            ST_SCALE: begin
               if (k_ff == '0) begin
                  state_ff <= ST_LOAD;
               end else begin
                  a_ff <= a_ff << 1;
                  k_ff <= k_ff - 1'b1;
               end
            end
            ST_LOAD: begin
               q_ff     <= an_ff;
               rem_ff   <= '0;
               cnt_ff   <= CNT_W'(DATA_WIDTH - 1);
               sel_ff   <= 1'b0;
               state_ff <= ST_DIV;
            end
            // Restoring division, one quotient bit per cycle.
            ST_DIV: begin
               if (cnt_ff == '0 && !sel_ff) begin
                  qn_ff  <= q_next;
                  q_ff   <= ad_ff;
                  rem_ff <= '0;
                  cnt_ff <= CNT_W'(DATA_WIDTH - 1);
                  sel_ff <= 1'b1;
               end else begin
                  if (borrow) begin
                     rem_ff <= rem_shift[DATA_WIDTH-1:0];
                  end else begin
                     rem_ff <= diff[DATA_WIDTH-1:0];
                  end
                  q_ff   <= q_next;
                  cnt_ff <= cnt_ff - 1'b1;
                  if (cnt_ff == '0) begin
                     qd_ff    <= q_next;
                     state_ff <= ST_SIGN;
                  end
               end
            end
            ST_SIGN: begin
               if (neg_ff) begin
                  qn_ff <= diff[DATA_WIDTH-1:0];
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status.idle        = (state_ff == ST_IDLE);
   assign status.done        = (state_ff == ST_DONE);
   assign result.numerator   = qn_ff;
   assign result.denominator = qd_ff[DATA_WIDTH-2:0];

endmodule : frn_core

`default_nettype wire

// ===== design/fraction_normalizer_top.sv =====
// Stream wrapper for the fraction normalizer: request intake, core and result register.
//
// Channel  Direction  Contents of tdata (lowest bits first)
// req      in         numerator_in[31:0], denominator_in[31:0]
// rsp      out        numerator_out[31:0], denominator_out[30:0], one zero pad bit
//
// A zero numerator goes straight to the result. A zero denominator runs through the
// magnitudes, two full-width restoring divisions on the shared subtractor, sign and hand-off.
// Any other request also strips the shared factors of two, runs the binary GCD steps and
// scales the divisor back up before the divisions.
// Reset is synchronous and active high; it empties the result register and idles the core.
// A stalled result holds its register, and req_tready stays low until the core's result moves in.
`timescale 1ns / 1ps
`default_nettype none

module fraction_normalizer_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // numerator_in, denominator_in
   input  wire logic [frn_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // numerator_out, denominator_out, zero padding
   output logic [frn_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   import frn_pkg::*;

   status_type               core_status;
   result_type               core_result;
   logic                     start;
   logic                     take;
   logic                     rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff;

   // A request enters only while the core is idle.
   assign req_tready = core_status.idle;
   assign start      = req_tvalid & req_tready;

   // The finished result moves over when the result register is free or draining.
   assign take = core_status.done & (~rsp_tvalid_ff | rsp_tready);

   frn_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .num_in (req_tdata[DATA_WIDTH-1:0]),
      .den_in (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .take   (take),
      .status (core_status),
      .result (core_result)
   );

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (take) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_tdata_ff <= RSP_TDATA_W'({core_result.denominator, core_result.numerator});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // An accepted request always takes the core out of idle in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("core accepted a request but stayed idle");

   // A zero numerator always comes out as 0/1.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[DATA_WIDTH-1:0] == '0)) |->
      (rsp_tdata[2*DATA_WIDTH-2:DATA_WIDTH] == (DATA_WIDTH-1)'(1)))
      else $error("zero numerator without unit denominator");

   // A new result only appears after the core finished its work.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(core_status.done))
      else $error("result appeared without a finished core");

endmodule : fraction_normalizer_top

`default_nettype wire
